// ===== sv/kibq_pkg.sv =====
`timescale 1ns / 1ps
package kibq_pkg;

   typedef struct packed {
      logic        mode;
      logic [7:0]  base_char;
      logic        seq_first;
      logic [15:0] base_pos;
   } req_type;

   typedef struct packed {
      logic [15:0] qry_offset;
      logic [15:0] hit_pos;
      logic        run_last;
   } rsp_type;

   localparam logic MODE_INDEX = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic REG_KMER_LEN = 1'b0;
   localparam logic REG_MASK_THR = 1'b1;

   localparam logic [3:0] KMER_LEN_RESET = 4'd8;
   localparam logic [5:0] MASK_THR_RESET = 6'd63;

   localparam logic [5:0] MAX_RESULTS = 6'd63;

   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_T = 8'h54;

   localparam logic [1:0] CODE_A = 2'd0;
   localparam logic [1:0] CODE_C = 2'd1;
   localparam logic [1:0] CODE_G = 2'd2;
   localparam logic [1:0] CODE_T = 2'd3;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_TUPD   = 5'b00100,
      ST_QCHECK = 5'b01000,
      ST_QWALK  = 5'b10000
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic tbl_upd;
      logic walk_start;
      logic walk_emit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic hit;
      logic walk_more;
   } sts_type;

   function automatic logic [1:0] base_code(input logic [7:0] c);
      logic [1:0] r;
      case (c)
         CHAR_C:  r = CODE_C;
         CHAR_G:  r = CODE_G;
         CHAR_T:  r = CODE_T;
         default: r = CODE_A;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/kibq_ram.sv =====
`timescale 1ns / 1ps
module kibq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/kibq_ctrl.sv =====
`timescale 1ns / 1ps
module kibq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             req_mode,
   input  kibq_pkg::sts_type sts,
   output kibq_pkg::cmd_type cmd,
   output logic             busy
);
   import kibq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (sts.clear_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (start) state_in = (req_mode == MODE_QUERY) ? ST_QCHECK : ST_TUPD;
         end
         ST_TUPD:   state_in = ST_IDLE;
         ST_QCHECK: state_in = sts.hit ? ST_QWALK : ST_IDLE;
         ST_QWALK:  if (!sts.walk_more) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd.clear_wr   = (state_ff == ST_CLEAR);
      cmd.accept     = (state_ff == ST_IDLE) && start;
      cmd.tbl_upd    = (state_ff == ST_TUPD);
      cmd.walk_start = (state_ff == ST_QCHECK);
      cmd.walk_emit  = (state_ff == ST_QWALK);
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== sv/kibq_dp.sv =====
`timescale 1ns / 1ps
module kibq_dp #(
   parameter int MAX_KMER_LEN = 8,
   parameter int POS_BITS     = 16,
   parameter int COUNT_BITS   = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  kibq_pkg::req_type req_data,
   input  kibq_pkg::cmd_type cmd,
   output kibq_pkg::sts_type sts,
   output logic              rsp_valid,
   output kibq_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata
);
   import kibq_pkg::*;

   localparam int IW    = 2 * MAX_KMER_LEN;
   localparam int KW    = $clog2(MAX_KMER_LEN + 1);
   localparam int MAXH  = MAX_KMER_LEN / 2;
   localparam int RW    = $clog2(MAXH + 1);
   localparam int TW    = 1 + COUNT_BITS + 2 * POS_BITS;
   localparam int CW    = (IW > POS_BITS) ? IW : POS_BITS;
   localparam logic [POS_BITS-1:0]   POS_MAX   = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // configuration
   logic [3:0] kmer_len_ff;
   logic [5:0] mask_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_len_ff <= KMER_LEN_RESET;
         mask_thr_ff <= MASK_THR_RESET;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == REG_KMER_LEN) kmer_len_ff <= pwdata[3:0];
         else                          mask_thr_ff <= pwdata[5:0];
      end
   end

   assign prdata = (paddr[2] == REG_KMER_LEN) ? {28'd0, kmer_len_ff} : {26'd0, mask_thr_ff};

   // effective k, mask, stride
   logic [KW-1:0]     k_eff;
   logic [KW-2:0]     half;
   logic [IW-1:0]     kmask;
   logic [RW-1:0]     rem_target;

   always_comb begin
      if (kmer_len_ff < 4'd2)                      k_eff = KW'(2);
      else if (kmer_len_ff > 4'(MAX_KMER_LEN))     k_eff = KW'(MAX_KMER_LEN);
      else                                         k_eff = KW'(kmer_len_ff);
      half       = k_eff[KW-1:1];
      kmask      = ~({IW{1'b1}} << (k_eff * 2));
      rem_target = (k_eff[0] && half > 1) ? RW'(1) : RW'(0);
   end

   // windows and counters
   logic [IW-1:0]       twin_ff, qwin_ff;
   logic [POS_BITS-1:0] tcnt_ff, qcnt_ff;
   logic [RW-1:0]       rem_ff [1:MAXH];
   logic [RW-1:0]       rem_eff [1:MAXH];
   logic [POS_BITS-1:0] tcnt_eff, qcnt_eff;
   logic [1:0]          code;
   logic [RW-1:0]       rem_sel;
   logic                ins_now, look_now;
   logic [IW-1:0]       idx_now;

   always_comb begin
      code     = base_code(req_data.base_char);
      tcnt_eff = req_data.seq_first ? '0 : tcnt_ff;
      qcnt_eff = req_data.seq_first ? '0 : qcnt_ff;
      rem_sel  = '0;
      for (int h = 1; h <= MAXH; h++) begin
         rem_eff[h] = req_data.seq_first ? '0 : rem_ff[h];
         if (32'(half) == h) rem_sel = rem_eff[h];
      end
      ins_now  = (tcnt_eff >= POS_BITS'(k_eff));
      look_now = (qcnt_eff >= POS_BITS'(k_eff)) && (rem_sel == rem_target);
      idx_now  = ((req_data.mode == MODE_QUERY) ? qwin_ff : twin_ff) & kmask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         twin_ff <= '0;
         qwin_ff <= '0;
         tcnt_ff <= '0;
         qcnt_ff <= '0;
         for (int h = 1; h <= MAXH; h++) rem_ff[h] <= '0;
      end else if (cmd.accept) begin
         if (req_data.mode == MODE_INDEX) begin
            twin_ff <= ((twin_ff << 2) | IW'(code)) & kmask;
            tcnt_ff <= (tcnt_eff != POS_MAX) ? tcnt_eff + 1'b1 : tcnt_eff;
         end else begin
            qwin_ff <= ((qwin_ff << 2) | IW'(code)) & kmask;
            qcnt_ff <= (qcnt_eff != POS_MAX) ? qcnt_eff + 1'b1 : qcnt_eff;
            for (int h = 1; h <= MAXH; h++) begin
               if (qcnt_eff != POS_MAX)
                  rem_ff[h] <= (32'(rem_eff[h]) == h - 1) ? '0 : rem_eff[h] + 1'b1;
               else
                  rem_ff[h] <= rem_eff[h];
            end
         end
      end
   end

   // per-item latches
   logic [IW-1:0]       idx_ff;
   logic [POS_BITS-1:0] p_ff, off_ff;
   logic                ins_ff, look_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ins_ff  <= 1'b0;
         look_ff <= 1'b0;
      end else if (cmd.accept) begin
         ins_ff  <= (req_data.mode == MODE_INDEX) && ins_now;
         look_ff <= (req_data.mode == MODE_QUERY) && look_now;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         idx_ff <= idx_now;
         p_ff   <= POS_BITS'({16'd0, req_data.base_pos} - 32'(k_eff));
         off_ff <= qcnt_eff - POS_BITS'(k_eff);
      end
   end

   // clearing sweep
   logic [CW-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (reset)             clr_ff <= '0;
      else if (cmd.clear_wr) clr_ff <= clr_ff + 1'b1;
   end

   // table and link memories
   logic                tbl_we, np_we;
   logic [IW-1:0]       tbl_waddr;
   logic [TW-1:0]       tbl_wdata, tbl_rdata;
   logic [POS_BITS-1:0] np_waddr, np_wdata, np_raddr, np_rdata;
   logic                old_valid;
   logic [COUNT_BITS-1:0] old_count;
   logic [POS_BITS-1:0] old_first, old_last;

   assign {old_valid, old_count, old_first, old_last} = tbl_rdata;

   always_comb begin
      if (cmd.clear_wr) begin
         tbl_we    = 1'b1;
         tbl_waddr = clr_ff[IW-1:0];
         tbl_wdata = '0;
         np_we     = 1'b1;
         np_waddr  = clr_ff[POS_BITS-1:0];
         np_wdata  = '0;
      end else begin
         tbl_we    = cmd.tbl_upd && ins_ff;
         tbl_waddr = idx_ff;
         tbl_wdata = {1'b1,
                      (old_count != COUNT_MAX) ? old_count + 1'b1 : old_count,
                      old_valid ? old_first : p_ff,
                      p_ff};
         np_we     = cmd.tbl_upd && ins_ff && old_valid;
         np_waddr  = old_last;
         np_wdata  = p_ff;
      end
      np_raddr = cmd.walk_start ? old_first : np_rdata;
   end

   kibq_ram #(.WIDTH(TW), .DEPTH(1 << IW)) u_tbl_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .raddr (idx_now),
      .rdata (tbl_rdata)
   );

   kibq_ram #(.WIDTH(POS_BITS), .DEPTH(1 << POS_BITS)) u_np_ram (
      .clock (clock),
      .we    (np_we),
      .waddr (np_waddr),
      .wdata (np_wdata),
      .raddr (np_raddr),
      .rdata (np_rdata)
   );

   // chain walk
   logic [POS_BITS-1:0] pos_ff;
   logic [5:0]          n_ff;
   logic                more;

   assign more = (np_rdata > pos_ff) && (n_ff != MAX_RESULTS - 6'd1);

   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         pos_ff <= old_first;
         n_ff   <= '0;
      end else if (cmd.walk_emit) begin
         pos_ff <= np_rdata;
         n_ff   <= n_ff + 1'b1;
      end
   end

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= cmd.walk_emit;
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_emit) begin
         rsp_data_ff.qry_offset <= 16'(32'(off_ff));
         rsp_data_ff.hit_pos    <= 16'(32'(pos_ff));
         rsp_data_ff.run_last   <= !more;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      sts.clear_last = &clr_ff;
      sts.hit        = look_ff && old_valid && (old_count <= COUNT_BITS'(mask_thr_ff));
      sts.walk_more  = more;
   end

endmodule

// ===== sv/kmer_index_build_and_query_core.sv =====
`timescale 1ns / 1ps
// K-mer position index and seed lookup. After reset the block sweeps its k-mer table and
// position-link memory, clearing every entry, with busy high. An index base does one table
// read-modify-write; for a query base with a hit, the chain walk emits the match pairs, reading
// one link from the position memory each cycle. Results appear one beat per cycle on rsp_valid
// and cannot be held off by the receiver, so a sink must take every beat as it comes.
module kmer_index_build_and_query_core #(
   parameter int MAX_KMER_LEN = 8,
   parameter int POS_BITS     = 16,
   parameter int COUNT_BITS   = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  kibq_pkg::req_type req_data,
   output logic              rsp_valid,
   output kibq_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import kibq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign pready = 1'b1;

   kibq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_data.mode),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   kibq_dp #(
      .MAX_KMER_LEN (MAX_KMER_LEN),
      .POS_BITS     (POS_BITS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata)
   );

endmodule
